// ===== src/assert_macros.svh =====
// Assertion macros used by the verification checker of the RTL folder.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== src/lcdss_pkg.sv =====
// Shared types, templates and helper functions of the LCD line status scraper.
// No dependencies; used by lcdss_line_scan and lcd_line_status_scraper.
package lcdss_pkg;

  localparam int LINE_LEN = 16;
  // Write index counts 0..LINE_LEN, so it needs one bit more than a position.
  localparam int POS_W = $clog2(LINE_LEN);
  localparam int IDX_W = POS_W + 1;

  typedef logic [7:0] char_t;
  // Character 0 of a line sits in the most significant byte, as in a string literal.
  typedef logic [0:LINE_LEN-1][7:0] line_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_CHAR  = 1'b1
  } req_e;

  localparam char_t WILDCARD    = 8'h7E;
  localparam char_t DIGIT_BASE  = 8'h30;
  localparam char_t UNKNOWN_VAL = 8'hFF;

  // The cooling, no-alarm and setpoint templates are padded with the wildcard, which matches anything.
  localparam line_t TPL_OFF_A   = "Unit is OFF     ";
  localparam line_t TPL_OFF_B   = "by ~/O key      ";
  localparam line_t TPL_STATUS  = " ~~~F    ~~ %RH ";
  localparam line_t TPL_COOL    = "COOLING~~~~~~~~~";
  localparam line_t TPL_NOALARM = "NO ALARMS~~~~~~~";
  localparam line_t TPL_SETPT   = "TEMP SETPT~~~~~~";

  typedef struct packed {
    logic  off_hit;
    logic  status_hit;
    logic  cool_hit;
    logic  noalarm_hit;
    logic  setpt_hit;
    char_t temp;
    char_t humidity;
    char_t setpoint;
  } scan_t;

  function automatic logic line_match(input line_t line, input line_t tpl);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < LINE_LEN; k++) begin
      if (line[k] != WILDCARD && tpl[k] != WILDCARD && line[k] != tpl[k]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Two ASCII digits to a number, everything modulo 256, no digit check.
  function automatic char_t two_digits(input char_t hi_c, input char_t lo_c);
    char_t hi;
    char_t lo;
    hi = hi_c - DIGIT_BASE;
    lo = lo_c - DIGIT_BASE;
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

// ===== src/lcdss_line_scan.sv =====
// Template compare and number parsing for one complete 16-character line.
// Depends on lcdss_pkg for the line type, templates and helper functions.
module lcdss_line_scan (
  input  lcdss_pkg::line_t line_i,
  output lcdss_pkg::scan_t scan_o
);
  import lcdss_pkg::*;

  always_comb begin
    scan_o.off_hit     = line_match(line_i, TPL_OFF_A) || line_match(line_i, TPL_OFF_B);
    scan_o.status_hit  = line_match(line_i, TPL_STATUS);
    scan_o.cool_hit    = line_match(line_i, TPL_COOL);
    scan_o.noalarm_hit = line_match(line_i, TPL_NOALARM);
    scan_o.setpt_hit   = line_match(line_i, TPL_SETPT);
    scan_o.temp        = two_digits(line_i[1], line_i[2]);
    scan_o.humidity    = two_digits(line_i[9], line_i[10]);
    scan_o.setpoint    = two_digits(line_i[12], line_i[13]);
  end

endmodule

// ===== src/lcd_line_status_scraper.sv =====
// Top level of the LCD line status scraper: handshake, per-display state, results.
// Depends on lcdss_pkg and instantiates lcdss_line_scan.
//
// The block watches characters drawn on up to two character LCDs. Each input
// transaction is a start-line request or one drawn character for a display.
// Every input transaction yields exactly one output transaction that carries
// the status of the addressed display after the update. When a display's 16th
// character arrives, the whole line is compared with fixed templates and the
// on flag, cooling flag, alarm flag and parsed readings are updated; that
// result carries line_done high. Characters past the 16th are ignored until
// the next start-line request. A display number at or above NUM_DISPLAYS
// changes nothing and reports all status fields as 0xFF.
// Both channels use valid and stall. An accepted transaction enters an input
// register and is processed into the output register when that register is
// free. The block accepts one transaction per cycle; the only limit is the
// output register: while it holds a stalled result and the input register is
// full, in_stall_o is raised.
// Reset (asynchronous, active low) empties both registers, zeroes the write
// indexes and sets every status field of every display to unknown (0xFF).
module lcd_line_status_scraper #(
  parameter int NUM_DISPLAYS = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic              display_i,
  input  lcdss_pkg::char_t  char_code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              line_done_o,
  output lcdss_pkg::char_t  unit_on_o,
  output lcdss_pkg::char_t  is_cooling_o,
  output lcdss_pkg::char_t  has_alarms_o,
  output lcdss_pkg::char_t  temp_reading_o,
  output lcdss_pkg::char_t  humidity_reading_o,
  output lcdss_pkg::char_t  setpoint_reading_o
);
  import lcdss_pkg::*;

  localparam int DISP_W = (NUM_DISPLAYS > 1) ? $clog2(NUM_DISPLAYS) : 1;

  // On flag has three values: unknown after reset, off, on.
  typedef enum logic [1:0] {
    ON_UNKNOWN = 2'b00,
    ON_OFF     = 2'b01,
    ON_ON      = 2'b10
  } on_e;

  // Input register.
  logic              s1_valid_q;
  logic              s1_req_q;
  logic              s1_disp_q;
  char_t             s1_char_q;

  // Output register.
  logic              out_valid_q;
  logic              out_done_q;
  char_t             out_on_q, out_cool_q, out_alarm_q;
  char_t             out_temp_q, out_hum_q, out_setpt_q;

  // Per-display state.
  line_t             line_q [NUM_DISPLAYS];
  logic [IDX_W-1:0]  wr_idx_q [NUM_DISPLAYS];
  logic [IDX_W-1:0]  wr_idx_d [NUM_DISPLAYS];
  on_e               on_q [NUM_DISPLAYS];
  on_e               on_d [NUM_DISPLAYS];
  logic [NUM_DISPLAYS-1:0] cool_seen_q, cool_seen_d;
  logic [NUM_DISPLAYS-1:0] alarm_clr_q, alarm_clr_d;
  char_t             temp_q [NUM_DISPLAYS];
  char_t             temp_d [NUM_DISPLAYS];
  char_t             hum_q [NUM_DISPLAYS];
  char_t             hum_d [NUM_DISPLAYS];
  char_t             setpt_q [NUM_DISPLAYS];
  char_t             setpt_d [NUM_DISPLAYS];

  logic              out_free, out_load, s1_free;
  logic              in_range, proc, store, last;
  logic [DISP_W-1:0] idx;
  logic [IDX_W-1:0]  cur_pos;
  line_t             scan_line;
  scan_t             scan;
  logic              done_d;
  char_t             on_out_d, cool_out_d, alarm_out_d;
  char_t             temp_out_d, hum_out_d, setpt_out_d;

  // Handshake: the output register frees when empty or taken this cycle, and the
  // input register frees when empty or when its transaction moves on to the output.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_req_q  <= req_type_i;
      s1_disp_q <= display_i;
      s1_char_q <= char_code_i;
    end
  end

  // Addressed display; an out-of-range number is steered to entry zero and masked.
  assign in_range = (int'(s1_disp_q) < NUM_DISPLAYS);
  assign idx      = in_range ? DISP_W'(s1_disp_q) : '0;
  assign cur_pos  = wr_idx_q[idx];
  assign proc     = out_load && in_range;
  assign store    = (s1_req_q == REQ_CHAR) && (cur_pos < IDX_W'(LINE_LEN));
  assign last     = (cur_pos == IDX_W'(LINE_LEN - 1));

  // The line under test is the stored row with the arriving character as its last.
  always_comb begin
    scan_line = line_q[idx];
    scan_line[LINE_LEN-1] = s1_char_q;
  end

  lcdss_line_scan u_line_scan (
    .line_i (scan_line),
    .scan_o (scan)
  );

  always_comb begin
    wr_idx_d    = wr_idx_q;
    on_d        = on_q;
    cool_seen_d = cool_seen_q;
    alarm_clr_d = alarm_clr_q;
    temp_d      = temp_q;
    hum_d       = hum_q;
    setpt_d     = setpt_q;
    done_d      = 1'b0;
    if (proc) begin
      if (s1_req_q == REQ_START) begin
        wr_idx_d[idx] = '0;
      end else if (store) begin
        wr_idx_d[idx] = cur_pos + IDX_W'(1);
        if (last) begin
          done_d = 1'b1;
          // Off templates win over everything; any other line means the unit is on
          // and at most the first matching status template takes effect.
          if (scan.off_hit) begin
            on_d[idx] = ON_OFF;
          end else begin
            on_d[idx] = ON_ON;
            if (scan.status_hit) begin
              temp_d[idx] = scan.temp;
              hum_d[idx]  = scan.humidity;
            end else if (scan.cool_hit) begin
              cool_seen_d[idx] = 1'b1;
            end else if (scan.noalarm_hit) begin
              alarm_clr_d[idx] = 1'b1;
            end else if (scan.setpt_hit) begin
              setpt_d[idx] = scan.setpoint;
            end
          end
        end
      end
    end
  end

  // Reported status is the addressed display's state after this update.
  always_comb begin
    case (on_d[idx])
      ON_OFF:  on_out_d = 8'h00;
      ON_ON:   on_out_d = 8'h01;
      default: on_out_d = UNKNOWN_VAL;
    endcase
    cool_out_d  = cool_seen_d[idx] ? 8'h01 : UNKNOWN_VAL;
    alarm_out_d = alarm_clr_d[idx] ? 8'h00 : UNKNOWN_VAL;
    temp_out_d  = temp_d[idx];
    hum_out_d   = hum_d[idx];
    setpt_out_d = setpt_d[idx];
    if (!in_range) begin
      on_out_d    = UNKNOWN_VAL;
      cool_out_d  = UNKNOWN_VAL;
      alarm_out_d = UNKNOWN_VAL;
      temp_out_d  = UNKNOWN_VAL;
      hum_out_d   = UNKNOWN_VAL;
      setpt_out_d = UNKNOWN_VAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_DISPLAYS; d++) begin
        wr_idx_q[d] <= '0;
        on_q[d]     <= ON_UNKNOWN;
        temp_q[d]   <= UNKNOWN_VAL;
        hum_q[d]    <= UNKNOWN_VAL;
        setpt_q[d]  <= UNKNOWN_VAL;
      end
      cool_seen_q <= '0;
      alarm_clr_q <= '0;
    end else begin
      wr_idx_q    <= wr_idx_d;
      on_q        <= on_d;
      cool_seen_q <= cool_seen_d;
      alarm_clr_q <= alarm_clr_d;
      temp_q      <= temp_d;
      hum_q       <= hum_d;
      setpt_q     <= setpt_d;
    end
  end

  // Every position of a line is rewritten before that line is scanned, so the
  // line buffer needs no reset value.
  always_ff @(posedge clk_i) begin
    if (proc && store) begin
      line_q[idx][cur_pos[POS_W-1:0]] <= s1_char_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_done_q  <= done_d;
      out_on_q    <= on_out_d;
      out_cool_q  <= cool_out_d;
      out_alarm_q <= alarm_out_d;
      out_temp_q  <= temp_out_d;
      out_hum_q   <= hum_out_d;
      out_setpt_q <= setpt_out_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign line_done_o        = out_done_q;
  assign unit_on_o          = out_on_q;
  assign is_cooling_o       = out_cool_q;
  assign has_alarms_o       = out_alarm_q;
  assign temp_reading_o     = out_temp_q;
  assign humidity_reading_o = out_hum_q;
  assign setpoint_reading_o = out_setpt_q;

endmodule

// ===== src/lcdss_checker.sv =====
// Port-level assertion checker for lcd_line_status_scraper, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lcdss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       line_done_o,
  input logic [7:0] unit_on_o,
  input logic [7:0] is_cooling_o,
  input logic [7:0] has_alarms_o,
  input logic [7:0] temp_reading_o
);

  // A stalled result stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(unit_on_o) && $stable(temp_reading_o) && $stable(line_done_o), "stalled result changed")

  // A processed line always leaves the display known to be on or off.
  `ASSERT_ALWAYS(a_done_on_known, clk_i, rst_ni, !(out_valid_o && line_done_o) || unit_on_o == 8'h00 || unit_on_o == 8'h01, "line done without known on flag")

  `ASSERT_ALWAYS(a_on_codes, clk_i, rst_ni, !out_valid_o || unit_on_o == 8'h00 || unit_on_o == 8'h01 || unit_on_o == 8'hFF, "bad on flag code")

  `ASSERT_ALWAYS(a_cool_codes, clk_i, rst_ni, !out_valid_o || is_cooling_o == 8'h01 || is_cooling_o == 8'hFF, "bad cooling flag code")

  `ASSERT_ALWAYS(a_alarm_codes, clk_i, rst_ni, !out_valid_o || has_alarms_o == 8'h00 || has_alarms_o == 8'hFF, "bad alarm flag code")

endmodule

bind lcd_line_status_scraper lcdss_checker u_lcdss_checker (.*);
